/* hw/rtl/avcc2b_pkg.sv */
// ----------------------------------------------------------------------------
// avcc2b_pkg
// Shared types for the length-prefix to start-code byte stream converter.
// ----------------------------------------------------------------------------
package avcc2b_pkg;

	// One input byte with its packet marks
	typedef struct packed {
		logic [7:0] in_byte;
		logic       payload_kind;
		logic       in_first;
		logic       in_last;
	} avcc_item_t;

	// One output byte of the start-code stream
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} annexb_item_t;

	// What one input byte produces: nothing, one byte, or a full start code
	typedef struct packed {
		logic       valid;
		logic       start;
		logic [7:0] data;
		logic       last;
	} parse_res_t;

endpackage

/* hw/rtl/avcc2b_parser.sv */
// ----------------------------------------------------------------------------
// avcc2b_parser
// Packet parser: holds the parse state and decides, for each accepted byte,
// which output it produces (none, one byte, or a 00 00 00 01 start code).
// ----------------------------------------------------------------------------
module avcc2b_parser #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  avcc2b_pkg::avcc_item_t  item,
	output avcc2b_pkg::parse_res_t  res
);
	import avcc2b_pkg::*;

	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_HDR    = 4'd1;
	localparam logic [3:0] PH_BODY   = 4'd2;
	localparam logic [3:0] PH_SKIP   = 4'd3;
	localparam logic [3:0] PH_SPSLEN = 4'd4;
	localparam logic [3:0] PH_SPS    = 4'd5;
	localparam logic [3:0] PH_PPSCNT = 4'd6;
	localparam logic [3:0] PH_PPSLEN = 4'd7;
	localparam logic [3:0] PH_PPS    = 4'd8;
	localparam logic [3:0] PH_DONE   = 4'd9;

	localparam logic [2:0]             SKIP_END = 3'd5;
	localparam logic [32:0]            LEN_MAX  = (33'd1 << LENGTH_BITS) - 33'd1;
	localparam logic [LENGTH_BITS-1:0] REM_ONE  = LENGTH_BITS'(1);

	logic [3:0]             phase_q, ph, nph;
	logic [2:0]             hpos_q, hp, nhp;
	logic [23:0]            gather_q, lg, nlg;
	logic [LENGTH_BITS-1:0] rem_q, rem, nrem;
	logic [31:0]            full_len;
	logic [15:0]            len16;
	logic                   over;
	logic [LENGTH_BITS-1:0] len_sat;

	always_comb begin
		// in_first restarts parsing before this byte is looked at
		ph  = item.in_first ? (item.payload_kind ? PH_SKIP : PH_HDR) : phase_q;
		hp  = item.in_first ? 3'd0 : hpos_q;
		lg  = item.in_first ? 24'd0 : gather_q;
		rem = item.in_first ? '0 : rem_q;

		full_len = {lg, item.in_byte};
		len16    = {lg[7:0], item.in_byte};
		over     = {1'b0, full_len} > LEN_MAX;
		len_sat  = over ? LEN_MAX[LENGTH_BITS-1:0] : full_len[LENGTH_BITS-1:0];

		nph  = ph;
		nhp  = hp;
		nlg  = lg;
		nrem = rem;
		res  = '0;

		unique case (ph)
			PH_HDR: begin
				res.valid = 1'b1;
				res.data  = (hp[1:0] == 2'd3) ? 8'h01 : 8'h00;
				if (hp[1:0] == 2'd3) begin
					nhp = 3'd0;
					nlg = 24'd0;
					if (len_sat != '0) begin
						nrem = len_sat;
						nph  = PH_BODY;
					end
				end else begin
					nhp = hp + 3'd1;
					nlg = {lg[15:0], item.in_byte};
				end
			end
			PH_BODY: begin
				res.valid = 1'b1;
				res.data  = item.in_byte;
				nrem      = rem - REM_ONE;
				if (rem == REM_ONE) begin
					nph = PH_HDR;
					nhp = 3'd0;
					nlg = 24'd0;
				end
			end
			PH_SKIP: begin
				if (hp >= SKIP_END) begin
					nph = PH_SPSLEN;
					nhp = 3'd0;
					nlg = 24'd0;
				end else begin
					nhp = hp + 3'd1;
				end
			end
			PH_SPSLEN, PH_PPSLEN: begin
				if (hp == 3'd0) begin
					nlg = {8'h00, len16};
					nhp = 3'd1;
				end else begin
					res.valid = 1'b1;
					res.start = 1'b1;
					nhp       = 3'd0;
					nlg       = 24'd0;
					nrem      = LENGTH_BITS'(len16);
					if (len16 != 16'd0) begin
						nph = (ph == PH_SPSLEN) ? PH_SPS : PH_PPS;
					end else if (ph == PH_SPSLEN) begin
						nph = PH_PPSCNT;
					end else begin
						// empty PPS: the start code closes the packet
						res.last = 1'b1;
						nph      = PH_DONE;
					end
				end
			end
			PH_SPS: begin
				res.valid = 1'b1;
				res.data  = item.in_byte;
				nrem      = rem - REM_ONE;
				if (rem == REM_ONE) nph = PH_PPSCNT;
			end
			PH_PPSCNT: begin
				nph = PH_PPSLEN;
				nhp = 3'd0;
				nlg = 24'd0;
			end
			PH_PPS: begin
				res.valid = 1'b1;
				res.data  = item.in_byte;
				res.last  = (rem == REM_ONE);
				nrem      = rem - REM_ONE;
				if (rem == REM_ONE) nph = PH_DONE;
			end
			default: begin
				// idle, done, and unused codes drop the byte
			end
		endcase

		if (item.in_last) begin
			if (res.valid) res.last = 1'b1;
			nph  = PH_IDLE;
			nhp  = 3'd0;
			nlg  = 24'd0;
			nrem = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			hpos_q   <= 3'd0;
			gather_q <= 24'd0;
			rem_q    <= '0;
		end else if (accept) begin
			phase_q  <= nph;
			hpos_q   <= nhp;
			gather_q <= nlg;
			rem_q    <= nrem;
		end
	end

endmodule

/* hw/rtl/h264_avcc_to_annexb_converter_core.sv */
// ----------------------------------------------------------------------------
// h264_avcc_to_annexb_converter_core
// Rewrites length-prefixed H.264 units and configuration records into a
// start-code delimited byte stream.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  avcc     | avcc_valid / avcc_stall  | in_byte, payload_kind, in_first/last
//  annexb   | annexb_valid/annexb_stall| out_byte, out_last
//
// One input byte per cycle while the output is not stalled and no start code is
// draining. A byte yields zero, one or four output bytes; the four-byte start
// code drains from the result register one byte at a time, and the next input
// byte is taken in the cycle the final pending byte leaves.
// Reset clears the parse state and empties the result register.
// A stalled output holds the input stalled once the result register is full.
module h264_avcc_to_annexb_converter_core #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      avcc_valid,
	output logic                      avcc_stall,
	input  avcc2b_pkg::avcc_item_t    avcc,
	output logic                      annexb_valid,
	input  logic                      annexb_stall,
	output avcc2b_pkg::annexb_item_t  annexb
);
	import avcc2b_pkg::*;

	parse_res_t res;
	logic       accept;
	logic       take;
	logic       final_byte;
	logic       done;

	logic       out_valid_q;
	logic       out_start_q;
	logic [7:0] out_data_q;
	logic       out_last_q;
	logic [1:0] idx_q;

	avcc2b_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (avcc),
		.res    (res)
	);

	assign final_byte = !out_start_q || (idx_q == 2'd3);
	assign take       = out_valid_q && !annexb_stall;
	assign done       = take && final_byte;
	assign avcc_stall = out_valid_q && !done;
	assign accept     = avcc_valid && !avcc_stall;

	assign annexb_valid    = out_valid_q;
	assign annexb.out_byte = out_start_q ? ((idx_q == 2'd3) ? 8'h01 : 8'h00) : out_data_q;
	assign annexb.out_last = out_last_q && final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (accept && res.valid) begin
			out_valid_q <= 1'b1;
			idx_q       <= 2'd0;
		end else if (done) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res.valid) begin
			out_start_q <= res.start;
			out_data_q  <= res.data;
			out_last_q  <= res.last;
		end
	end

endmodule

/* hw/rtl/avcc2b_checker.sv */
// ----------------------------------------------------------------------------
// avcc2b_checker
// Port-level checks for the start-code converter, bound to the top level.
// ----------------------------------------------------------------------------
module avcc2b_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      avcc_valid,
	input logic                      avcc_stall,
	input avcc2b_pkg::avcc_item_t    avcc,
	input logic                      annexb_valid,
	input logic                      annexb_stall,
	input avcc2b_pkg::annexb_item_t  annexb
);
	import avcc2b_pkg::*;

	// stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		annexb_valid && annexb_stall |=> annexb_valid && $stable(annexb))
		else $error("output changed while stalled");

	// nothing pending means input is never held off
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!annexb_valid |-> !avcc_stall)
		else $error("input stalled with empty result register");

	// a stalled output keeps the input stalled
	a_back_press: assert property (@(posedge clk) disable iff (!arst_n)
		annexb_valid && annexb_stall |-> avcc_stall)
		else $error("input accepted while output stalled");

	// first byte of a length-prefixed packet comes out as a zero header byte
	a_hdr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		avcc_valid && !avcc_stall && avcc.in_first && !avcc.payload_kind
		|=> annexb_valid && (annexb.out_byte == 8'h00)
			&& (annexb.out_last == $past(avcc.in_last)))
		else $error("header byte of new packet wrong");

endmodule

bind h264_avcc_to_annexb_converter_core avcc2b_checker u_avcc2b_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.avcc_valid   (avcc_valid),
	.avcc_stall   (avcc_stall),
	.avcc         (avcc),
	.annexb_valid (annexb_valid),
	.annexb_stall (annexb_stall),
	.annexb       (annexb)
);
